[hdl/ldmc_pkg.sv]
`default_nettype none

package ldmc_pkg;

   // action codes
   localparam logic [1:0] ACT_KEY    = 2'd0;
   localparam logic [1:0] ACT_BUTTON = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   // button ids
   localparam logic [1:0] BTN_TOGGLE = 2'd1;
   localparam logic [1:0] BTN_NEXT   = 2'd2;
   localparam logic [1:0] BTN_PREV   = 2'd3;

   // terminal keys (ASCII)
   localparam logic [7:0] KEY_ON    = 8'h6F; // o
   localparam logic [7:0] KEY_MORE  = 8'h3E; // >
   localparam logic [7:0] KEY_LESS  = 8'h3C; // <
   localparam logic [7:0] KEY_LOCK  = 8'h6C; // l
   localparam logic [7:0] KEY_NEXT  = 8'h6D; // m
   localparam logic [7:0] KEY_PREV  = 8'h6E; // n
   localparam logic [7:0] KEY_MAX   = 8'h77; // w
   localparam logic [7:0] KEY_MIN   = 8'h73; // s
   localparam logic [7:0] KEY_THR   = 8'h67; // g
   localparam logic [7:0] KEY_SPEED = 8'h74; // t
   localparam logic [7:0] KEY_CLEAR = 8'h63; // c
   localparam logic [7:0] KEY_ZERO  = 8'h30;
   localparam logic [7:0] KEY_NINE  = 8'h39;

   // lamp modes
   localparam logic [1:0] MODE_MANUAL = 2'd0;
   localparam logic [1:0] MODE_DIMMER = 2'd1;
   localparam logic [1:0] MODE_SWITCH = 2'd2;
   localparam logic [1:0] MODE_ADJUST = 2'd3;

   // pending terminal command
   localparam logic [1:0] TCMD_NONE = 2'd0;
   localparam logic [1:0] TCMD_ON   = 2'd1;
   localparam logic [1:0] TCMD_MORE = 2'd2;
   localparam logic [1:0] TCMD_LESS = 2'd3;

   // configuration register indexes
   localparam logic CSR_DIMMER_STEP = 1'b0;
   localparam logic CSR_AUTO_BAND   = 1'b1;

   localparam int unsigned MV_FULL    = 3300;
   localparam int unsigned ADC_FULL   = 1023;
   localparam logic [6:0]  LEVEL_FULL = 7'd100;
   localparam logic [6:0]  STEP_RST   = 7'd10;
   localparam logic [11:0] BAND_RST   = 12'd100;
   localparam logic [15:0] THR_RST    = 16'd2500;
   localparam logic [15:0] ENTRY_SAT  = 16'hFFFF;

   localparam int unsigned PROD_W      = 22;  // adc * 3300
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_DIGIT,
      CMD_TERM_ON,
      CMD_TERM_MORE,
      CMD_TERM_LESS,
      CMD_LOCK,
      CMD_MODE_NEXT,
      CMD_MODE_PREV,
      CMD_STORE_MAX,
      CMD_STORE_MIN,
      CMD_STORE_THR,
      CMD_STORE_SPEED,
      CMD_CLEAR,
      CMD_BTN_TOGGLE,
      CMD_BTN_NEXT,
      CMD_BTN_PREV,
      CMD_TICK
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] key_code;
      logic [1:0] button_id;
      logic [9:0] adc_code;
   } req_type;

   typedef struct packed {
      logic [6:0] intensity;
      logic [9:0] pwm_compare;
      logic [1:0] mode;
      logic       locked;
   } rsp_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  digit;
      logic [11:0] light_mv;
   } item_type;

endpackage

`default_nettype wire

[hdl/ldmc_front.sv]
`default_nettype none

module ldmc_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  ldmc_pkg::req_type     req_data,
   output logic                  push,
   output ldmc_pkg::item_type    push_item,
   input  wire                   queue_full
);
   import ldmc_pkg::*;

   logic              valid_ff, valid_in;
   cmd_type           cmd_ff, cmd_in;
   logic [3:0]        digit_ff, digit_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              accept;

   logic [PROD_W:0]   sum_est;
   logic [11:0]       q_est;
   logic [PROD_W-1:0] q_times;
   logic [PROD_W-1:0] rem;
   logic [11:0]       mv;

   assign push      = valid_ff && !queue_full;
   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   // decode the transaction into one command
   always_comb begin
      cmd_in   = CMD_NONE;
      digit_in = req_data.key_code[3:0];
      prod_in  = PROD_W'(req_data.adc_code) * PROD_W'(MV_FULL);
      case (req_data.action)
         ACT_KEY: begin
            if (req_data.key_code >= KEY_ZERO && req_data.key_code <= KEY_NINE) begin
               cmd_in = CMD_DIGIT;
            end else begin
               case (req_data.key_code)
                  KEY_ON:    cmd_in = CMD_TERM_ON;
                  KEY_MORE:  cmd_in = CMD_TERM_MORE;
                  KEY_LESS:  cmd_in = CMD_TERM_LESS;
                  KEY_LOCK:  cmd_in = CMD_LOCK;
                  KEY_NEXT:  cmd_in = CMD_MODE_NEXT;
                  KEY_PREV:  cmd_in = CMD_MODE_PREV;
                  KEY_MAX:   cmd_in = CMD_STORE_MAX;
                  KEY_MIN:   cmd_in = CMD_STORE_MIN;
                  KEY_THR:   cmd_in = CMD_STORE_THR;
                  KEY_SPEED: cmd_in = CMD_STORE_SPEED;
                  KEY_CLEAR: cmd_in = CMD_CLEAR;
                  default:   cmd_in = CMD_NONE;
               endcase
            end
         end
         ACT_BUTTON: begin
            case (req_data.button_id)
               BTN_TOGGLE: cmd_in = CMD_BTN_TOGGLE;
               BTN_NEXT:   cmd_in = CMD_BTN_NEXT;
               BTN_PREV:   cmd_in = CMD_BTN_PREV;
               default:    cmd_in = CMD_NONE;
            endcase
         end
         ACT_TICK: cmd_in = CMD_TICK;
         default:  cmd_in = CMD_NONE;
      endcase
   end

   assign valid_in = accept || (valid_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_in;
         digit_ff <= digit_in;
         prod_ff  <= prod_in;
      end
   end

   // prod / 1023: series estimate x/1024 * (1 + 2^-10 + 2^-20) is low by at most one,
   // one remainder check fixes it
   always_comb begin
      sum_est = {1'b0, prod_ff} + {11'b0, prod_ff[PROD_W-1:10]}
              + {21'b0, prod_ff[PROD_W-1:20]};
      q_est   = sum_est[21:10];
      q_times = {q_est, 10'b0} - PROD_W'(q_est);
      rem     = prod_ff - q_times;
      mv      = (rem >= PROD_W'(ADC_FULL)) ? q_est + 12'd1 : q_est;
   end

   assign push_item.cmd      = cmd_ff;
   assign push_item.digit    = digit_ff;
   assign push_item.light_mv = mv;

endmodule

`default_nettype wire

[hdl/ldmc_queue.sv]
`default_nettype none

module ldmc_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ldmc_pkg::item_type   push_item,
   output logic                 full,
   input  wire                  pop,
   output logic                 not_empty,
   output ldmc_pkg::item_type   head_item
);
   import ldmc_pkg::*;

   item_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[hdl/ldmc_back.sv]
`default_nettype none

module ldmc_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_write_en,
   input  wire                  csr_index,
   input  wire  [11:0]          csr_wdata,
   input  wire                  item_valid,
   input  ldmc_pkg::item_type   item,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output ldmc_pkg::rsp_type    rsp_data
);
   import ldmc_pkg::*;

   logic [6:0]  step_ff;
   logic [11:0] band_ff;

   logic [1:0]  mode_ff, mode_in;
   logic        lock_ff, lock_in;
   logic        press_ff, press_in;
   logic [1:0]  tcmd_ff, tcmd_in;
   logic [6:0]  level_ff, level_in;
   logic [6:0]  saved_ff, saved_in;
   logic [6:0]  min_ff, min_in;
   logic [6:0]  max_ff, max_in;
   logic [15:0] thr_ff, thr_in;
   logic [6:0]  speed_ff, speed_in;
   logic [15:0] entry_ff, entry_in;

   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;
   logic        go;

   logic        toggle;
   logic [19:0] entry_next;
   logic [6:0]  lvl_c, saved_c;
   logic [7:0]  dim_up;
   logic        dim_dn_ok;
   logic [7:0]  ramp_up;
   logic [16:0] thr_hi;
   logic [16:0] mv_lo;
   logic        bright;

   assign go  = item_valid && (!out_valid_ff || !rsp_stall);
   assign pop = go;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RST;
         band_ff <= BAND_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DIMMER_STEP: step_ff <= csr_wdata[6:0];
            CSR_AUTO_BAND:   band_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   always_comb begin
      toggle     = (tcmd_ff == TCMD_ON) || (!lock_ff && press_ff);
      entry_next = ({4'b0, entry_ff} << 3) + ({4'b0, entry_ff} << 1) + {16'b0, item.digit};

      if (level_ff < min_ff) begin
         lvl_c = min_ff;
      end else if (level_ff > max_ff) begin
         lvl_c = max_ff;
      end else begin
         lvl_c = level_ff;
      end
      if (saved_ff < min_ff) begin
         saved_c = min_ff;
      end else if (saved_ff > max_ff) begin
         saved_c = max_ff;
      end else begin
         saved_c = saved_ff;
      end
      dim_up    = {1'b0, lvl_c} + {1'b0, step_ff};
      dim_dn_ok = {1'b0, lvl_c} >= ({1'b0, min_ff} + {1'b0, step_ff});

      ramp_up = {1'b0, level_ff} + {1'b0, speed_ff};
      bright  = {4'b0, item.light_mv} > thr_ff;
      thr_hi  = {1'b0, thr_ff} + {5'b0, band_ff};
      mv_lo   = {5'b0, item.light_mv} + {5'b0, band_ff};
   end

   always_comb begin
      mode_in  = mode_ff;
      lock_in  = lock_ff;
      press_in = press_ff;
      tcmd_in  = tcmd_ff;
      level_in = level_ff;
      saved_in = saved_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      thr_in   = thr_ff;
      speed_in = speed_ff;
      entry_in = entry_ff;
      if (go) begin
         case (item.cmd)
            CMD_DIGIT: entry_in = (entry_next > 20'(ENTRY_SAT)) ? ENTRY_SAT : entry_next[15:0];
            CMD_TERM_ON:   tcmd_in = TCMD_ON;
            CMD_TERM_MORE: tcmd_in = TCMD_MORE;
            CMD_TERM_LESS: tcmd_in = TCMD_LESS;
            CMD_LOCK:      lock_in = !lock_ff;
            CMD_MODE_NEXT: mode_in = mode_ff + 2'd1;
            CMD_MODE_PREV: mode_in = mode_ff - 2'd1;
            CMD_STORE_MAX: begin
               if (entry_ff >= {9'b0, min_ff} && entry_ff <= {9'b0, LEVEL_FULL}) begin
                  max_in = entry_ff[6:0];
               end
               entry_in = '0;
            end
            CMD_STORE_MIN: begin
               if (entry_ff <= {9'b0, max_ff}) begin
                  min_in = entry_ff[6:0];
               end
               entry_in = '0;
            end
            CMD_STORE_THR: begin
               thr_in   = entry_ff;
               entry_in = '0;
            end
            CMD_STORE_SPEED: begin
               if (entry_ff <= {9'b0, LEVEL_FULL}) begin
                  speed_in = entry_ff[6:0];
               end
               entry_in = '0;
            end
            CMD_CLEAR:      entry_in = '0;
            CMD_BTN_TOGGLE: press_in = !press_ff;
            CMD_BTN_NEXT: begin
               if (!lock_ff) begin
                  mode_in = mode_ff + 2'd1;
               end
            end
            CMD_BTN_PREV: begin
               if (!lock_ff) begin
                  mode_in = mode_ff - 2'd1;
               end
            end
            CMD_TICK: begin
               case (mode_ff)
                  MODE_MANUAL: begin
                     if (toggle) begin
                        level_in = (level_ff == 7'd0) ? LEVEL_FULL : 7'd0;
                     end
                     press_in = 1'b0;
                     tcmd_in  = TCMD_NONE;
                  end
                  MODE_DIMMER: begin
                     level_in = lvl_c;
                     if (toggle) begin
                        if (lvl_c > min_ff) begin
                           saved_in = lvl_c;
                           level_in = min_ff;
                        end else begin
                           level_in = saved_c;
                        end
                     end else if (tcmd_ff == TCMD_MORE) begin
                        if (dim_up <= {1'b0, max_ff}) begin
                           level_in = dim_up[6:0];
                           saved_in = dim_up[6:0];
                        end
                     end else if (tcmd_ff == TCMD_LESS) begin
                        if (dim_dn_ok) begin
                           level_in = lvl_c - step_ff;
                           saved_in = lvl_c - step_ff;
                        end
                     end
                     press_in = 1'b0;
                     tcmd_in  = TCMD_NONE;
                  end
                  MODE_SWITCH: begin
                     if (bright) begin
                        if (level_ff <= max_ff) begin
                           level_in = (ramp_up > {1'b0, LEVEL_FULL}) ? max_ff : ramp_up[6:0];
                        end
                     end else if (level_ff >= min_ff) begin
                        level_in = (level_ff < speed_ff) ? min_ff : level_ff - speed_ff;
                     end
                  end
                  default: begin
                     if ({5'b0, item.light_mv} > thr_hi && level_ff < max_ff) begin
                        level_in = level_ff + 7'd1;
                     end else if (mv_lo < {1'b0, thr_ff} && level_ff > min_ff) begin
                        level_in = level_ff - 7'd1;
                     end
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_MANUAL;
         lock_ff  <= 1'b0;
         press_ff <= 1'b0;
         tcmd_ff  <= TCMD_NONE;
         level_ff <= 7'd0;
         saved_ff <= LEVEL_FULL;
         min_ff   <= 7'd0;
         max_ff   <= LEVEL_FULL;
         thr_ff   <= THR_RST;
         speed_ff <= 7'd1;
         entry_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         lock_ff  <= lock_in;
         press_ff <= press_in;
         tcmd_ff  <= tcmd_in;
         level_ff <= level_in;
         saved_ff <= saved_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         thr_ff   <= thr_in;
         speed_ff <= speed_in;
         entry_ff <= entry_in;
      end
   end

   // result register: loads on every executed transaction
   always_comb begin
      out_valid_in            = go || (out_valid_ff && rsp_stall);
      out_data_in.intensity   = level_in;
      out_data_in.pwm_compare = ({3'b0, level_in} << 3) + ({3'b0, level_in} << 1);
      out_data_in.mode        = mode_in;
      out_data_in.locked      = lock_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[hdl/lamp_dimmer_mode_controller.sv]
`default_nettype none

// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_stall    req_data   (action, key_code, button_id, adc_code)
// rsp       out        rsp_valid / rsp_stall    rsp_data   (intensity, pwm_compare, mode, locked)
// csr       in         csr_write_en             csr_index, csr_wdata (dimmer_step, auto_band)
//
// One transaction per cycle sustained while neither stall holds; an accepted req passes
// the decode/multiply register, then a queue slot, then the result register, whose
// loading raises rsp_valid.
// The front decodes and scales the ADC sample (x3300, /1023 by reciprocal estimate);
// the back applies one command per cycle to the lamp state while rsp_stall does not hold it.
// A four-entry queue separates them, so req keeps flowing while rsp_stall holds the back, until the queue fills.
// Synchronous active-high reset; control and lamp state return to their reset values (data registers are not reset).

module lamp_dimmer_mode_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  ldmc_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output ldmc_pkg::rsp_type    rsp_data,
   input  wire                  csr_write_en,
   input  wire                  csr_index,
   input  wire  [11:0]          csr_wdata
);
   import ldmc_pkg::*;

   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     pop;
   logic     not_empty;
   item_type head_item;

   ldmc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   ldmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   ldmc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item_valid   (not_empty),
      .item         (head_item),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire
